// ===== rtl/core/lie_pkg.sv =====
// Shared widths, controller types and the weight table of the loss-interval estimator.
package lie_pkg;

    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned IVL_W  = 32;
    localparam int unsigned AVG_W  = 40;
    localparam int unsigned FRAC_W = 8;
    localparam logic [IVL_W-1:0] IVL_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } lie_state_t;

    typedef struct packed {
        logic accept;      // take the input beat and update the history
        logic accum_step;  // add one weighted term to both sums
        logic div_start;   // load the dividend and clear the remainder
        logic div_step;    // one restoring division step
        logic load_out;    // copy the result into the output register
    } lie_cmd_t;

    typedef struct packed {
        logic need_avg;    // history after this beat holds a full pair of spans
        logic accum_last;  // the final term is being added
        logic div_last;    // the final quotient bit is being formed
    } lie_status_t;

    // Weight of term i over n terms, newest first: n+2 for the first half, 2*(n-i) after.
    function automatic logic [4:0] weight_of(input logic [4:0] i, input logic [4:0] n);
        logic [4:0] w;
        if (i < (n >> 1))
        begin
            w = n + 5'd2;
        end
        else
        begin
            w = (n - i) << 1;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/lie_dpath.sv =====
// Interval history, weighted sums and serial divider of the loss-interval estimator.
module lie_dpath
    import lie_pkg::*;
#(
    parameter int unsigned INTERVAL_DEPTH = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lie_cmd_t            cmd,
    output lie_status_t         status,
    input  logic [SEQ_W-1:0]    sequence_req,
    input  logic                history_empty,
    output logic                valid_res,
    output logic [AVG_W-1:0]    avg_interval,
    output logic [IVL_W-1:0]    current_interval
);

    localparam int unsigned NTERMS = INTERVAL_DEPTH - 1;
    localparam int unsigned CNT_W  = $clog2(INTERVAL_DEPTH + 1);
    localparam int unsigned IDX_W  = $clog2(NTERMS);
    localparam int unsigned WGT_W  = $clog2(NTERMS + 3);
    localparam int unsigned PROD_W = IVL_W + WGT_W;
    localparam int unsigned SUM_W  = PROD_W + $clog2(NTERMS + 1);
    localparam int unsigned WS_W   = WGT_W + $clog2(NTERMS + 1);
    localparam int unsigned DIV_W  = SUM_W + FRAC_W;
    localparam int unsigned DCNT_W = $clog2(DIV_W);

    logic [IVL_W-1:0]  store_reg [INTERVAL_DEPTH];
    logic [IVL_W-1:0]  store_next [INTERVAL_DEPTH];
    logic [IVL_W-1:0]  work_reg [INTERVAL_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  expected_reg, expected_next;
    logic              seen_reg, seen_next;

    logic [IVL_W-1:0]  store_base [INTERVAL_DEPTH];
    logic [CNT_W-1:0]  count_base;
    logic [SEQ_W-1:0]  expected_base;
    logic              seen_base;
    logic              in_order;

    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  s0_reg, s1_reg;
    logic [WS_W-1:0]   w_reg;
    logic [WGT_W-1:0]  wt;
    logic [PROD_W-1:0] p0, p1;
    logic [SUM_W-1:0]  max_sum;

    logic [DIV_W-1:0]  quo_reg;
    logic [WS_W-1:0]   rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [WS_W:0]     rem_shift;
    logic              rem_ge;

    logic              valid_res_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic [IVL_W-1:0]  cur_reg;

    // History update for the incoming beat; a restart clears first.
    always_comb
    begin
        for (int i = 0; i < INTERVAL_DEPTH; i++)
        begin
            store_base[i] = history_empty ? '0 : store_reg[i];
        end
        count_base    = history_empty ? CNT_W'(1) : count_reg;
        expected_base = history_empty ? sequence_req : expected_reg;
        seen_base     = history_empty ? 1'b0 : seen_reg;
        in_order      = (sequence_req == expected_base);

        if (in_order)
        begin
            for (int i = 0; i < INTERVAL_DEPTH; i++)
            begin
                store_next[i] = store_base[i];
            end
            if (store_base[0] != IVL_MAX)
            begin
                store_next[0] = store_base[0] + IVL_W'(1);
            end
            count_next    = count_base;
            expected_next = expected_base + SEQ_W'(1);
            seen_next     = seen_base;
        end
        else
        begin
            store_next[0] = IVL_W'(1);
            for (int i = 1; i < INTERVAL_DEPTH; i++)
            begin
                store_next[i] = store_base[i-1];
            end
            count_next    = (count_base < CNT_W'(INTERVAL_DEPTH)) ?
                            count_base + CNT_W'(1) : count_base;
            expected_next = sequence_req + SEQ_W'(1);
            seen_next     = 1'b1;
        end
    end

    assign status.need_avg   = seen_next && (count_next >= CNT_W'(2));
    assign status.accum_last = ({{(CNT_W-IDX_W){1'b0}}, idx_reg} == count_reg - CNT_W'(2));
    assign status.div_last   = (dcnt_reg == DCNT_W'(DIV_W - 1));

    assign wt      = WGT_W'(weight_of(5'(idx_reg), 5'(NTERMS)));
    assign p0      = PROD_W'(work_reg[0]) * PROD_W'(wt);
    assign p1      = PROD_W'(work_reg[1]) * PROD_W'(wt);
    assign max_sum = (s0_reg > s1_reg) ? s0_reg : s1_reg;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, w_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < INTERVAL_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
            count_reg    <= CNT_W'(1);
            expected_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            for (int i = 0; i < INTERVAL_DEPTH; i++)
            begin
                store_reg[i] <= store_next[i];
            end
            count_reg    <= count_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
        end
    end

    // Working copy shifts down so the two taps always see terms idx and idx+1.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < INTERVAL_DEPTH; i++)
            begin
                work_reg[i] <= store_next[i];
            end
            idx_reg <= '0;
            s0_reg  <= '0;
            s1_reg  <= '0;
            w_reg   <= '0;
            quo_reg <= '0;
        end
        else if (cmd.accum_step)
        begin
            for (int i = 0; i < INTERVAL_DEPTH - 1; i++)
            begin
                work_reg[i] <= work_reg[i+1];
            end
            idx_reg <= idx_reg + IDX_W'(1);
            s0_reg  <= s0_reg + SUM_W'(p0);
            s1_reg  <= s1_reg + SUM_W'(p1);
            w_reg   <= w_reg + WS_W'(wt);
        end
        else if (cmd.div_start)
        begin
            quo_reg  <= {max_sum, {FRAC_W{1'b0}}};
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? WS_W'(rem_shift - {1'b0, w_reg}) : rem_shift[WS_W-1:0];
            quo_reg  <= {quo_reg[DIV_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            valid_res_reg <= seen_reg;
            avg_reg       <= seen_reg ? quo_reg[AVG_W-1:0] : '0;
            cur_reg       <= store_reg[0];
        end
    end

    assign valid_res        = valid_res_reg;
    assign avg_interval     = avg_reg;
    assign current_interval = cur_reg;

endmodule

// ===== rtl/core/lie_ctrl.sv =====
// Sequencing state machine and handshake control of the loss-interval estimator.
module lie_ctrl
    import lie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  lie_status_t status,
    output lie_cmd_t    cmd
);

    lie_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_avg ? ST_ACCUM : ST_DONE;
                end
            end
            ST_ACCUM:
            begin
                if (status.accum_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:   cmd.accept     = in_valid;
            ST_ACCUM:  cmd.accum_step = 1'b1;
            ST_LOAD:   cmd.div_start  = 1'b1;
            ST_DIVIDE: cmd.div_step   = 1'b1;
            ST_DONE:   cmd.load_out   = out_free;
            default:   cmd = '0;
        endcase
    end

    // Hold the result beat until taken; a fresh load may replace a beat taken this cycle.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/loss_interval_estimator.sv =====
// Top level of the loss-interval estimator: controller and datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   sequence_req, history_empty
//   out      output     out_valid / out_stall valid_res, avg_interval, current_interval
//
// Each beat first updates the history, then forms the weighted sums over count-1 terms
// (at most INTERVAL_DEPTH-1), takes a load step, runs the restoring divider at one cycle per
// quotient bit (48 quotient bits for depth 9) and then hands over the result. Beats
// before the first loss skip the sums and divider. Reset clears the history at once; no
// sweep. A stalled result beat holds in the output register while the next input beat
// is taken.
module loss_interval_estimator
    import lie_pkg::*;
#(
    parameter int unsigned INTERVAL_DEPTH = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [SEQ_W-1:0] sequence_req,
    input  logic             history_empty,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             valid_res,
    output logic [AVG_W-1:0] avg_interval,
    output logic [IVL_W-1:0] current_interval
);

    lie_cmd_t    cmd;
    lie_status_t status;

    lie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lie_dpath #(
        .INTERVAL_DEPTH (INTERVAL_DEPTH)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sequence_req     (sequence_req),
        .history_empty    (history_empty),
        .valid_res        (valid_res),
        .avg_interval     (avg_interval),
        .current_interval (current_interval)
    );

endmodule
